### src/ttmr_pkg.sv
// Shared types and constants for the triple match-and-reload timer block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ttmr_pkg;

    localparam int MAX_TIMERS = 3;
    localparam int DATA_W     = 32;
    localparam int FLAG_W     = 9;
    localparam int CTRL_W     = 12;

    // Transaction kinds
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Register map: 4*timer + field, then the global registers
    localparam logic [1:0] BANK_GLOBAL = 2'd3;
    localparam logic [1:0] SEL_COUNT   = 2'd0;
    localparam logic [1:0] SEL_RELOAD  = 2'd1;
    localparam logic [1:0] SEL_MATCH1  = 2'd2;
    localparam logic [1:0] SEL_MATCH2  = 2'd3;
    localparam logic [3:0] REG_CONTROL = 4'd12;
    localparam logic [3:0] REG_STATUS  = 4'd13;
    localparam logic [3:0] REG_ACK     = 4'd14;

    typedef struct packed {
        logic [1:0]        func;
        logic [3:0]        reg_index;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] slow_ticks;
        logic [DATA_W-1:0] fast_ticks;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [FLAG_W-1:0] irq_flags;
    } out_item_t;

    // Per-timer control, unpacked from the control word
    typedef struct packed {
        logic enable;
        logic slow_sel;
        logic zero_irq_en;
        logic count_up;
    } tmr_ctrl_t;

    // Per-timer flags, match1 in the low bit to line up with the status word
    typedef struct packed {
        logic reloaded;
        logic match2;
        logic match1;
    } tmr_flags_t;

endpackage

### src/ttmr_lane.sv
// One timer lane: count step, match and zero-crossing checks for a tick.
// Depends on ttmr_pkg.
`timescale 1ns / 1ps

module ttmr_lane (
    input  ttmr_pkg::tmr_ctrl_t         ctrl,
    input  logic [ttmr_pkg::DATA_W-1:0] count,
    input  logic [ttmr_pkg::DATA_W-1:0] reload,
    input  logic [ttmr_pkg::DATA_W-1:0] match1,
    input  logic [ttmr_pkg::DATA_W-1:0] match2,
    input  logic [ttmr_pkg::DATA_W-1:0] slow_ticks,
    input  logic [ttmr_pkg::DATA_W-1:0] fast_ticks,
    output logic [ttmr_pkg::DATA_W-1:0] count_next,
    output ttmr_pkg::tmr_flags_t        flags
);
    import ttmr_pkg::*;

    logic [DATA_W-1:0] step;
    logic [DATA_W-1:0] stepped;
    logic [DATA_W-1:0] base;
    logic              hit1;
    logic              hit2;
    logic              hit_zero;

    // The crossed span has length step; measure each point from its low end
    assign step    = ctrl.slow_sel ? slow_ticks : fast_ticks;
    assign stepped = ctrl.count_up ? count + step : count - step;
    assign base    = ctrl.count_up ? count : stepped;

    assign hit1     = (match1 - base) <= step;
    assign hit2     = (match2 - base) <= step;
    assign hit_zero = (DATA_W'(0) - base) <= step;

    always_comb
    begin
        flags      = '0;
        count_next = count;
        if (ctrl.enable)
        begin
            flags.match1   = hit1;
            flags.match2   = hit2;
            flags.reloaded = ctrl.zero_irq_en && (count != '0) && hit_zero;
            count_next     = flags.reloaded ? reload : stepped;
        end
    end

endmodule

### src/triple_timer_match_reload.sv
// Top level of the triple match-and-reload timer: register file, input and
// result registers, and one ttmr_lane per timer. Depends on ttmr_pkg, ttmr_lane.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready/in_data) carries one transaction per
//   item: a register read, a register write or a time tick. Output channel
//   (out_valid/out_ready/out_data) returns exactly one result per item: the
//   read value (zero for writes and ticks) and the status flags after it.
//   Path: an accepted item is captured in the input register, processed
//   into the result register when that register is free or draining, and
//   is offered on the output from then on. Throughput: one item per cycle
//   while out_ready stays high; the timers update in parallel, one adder
//   and three span comparators each, between the two registers.
//   Stall: when out_ready is low the result register holds, the input
//   register holds one more item, and in_ready drops only when both are full.
//   Reset (rst_n low, asynchronous): all counters, reload and match values,
//   control, status and pending acknowledge clear to zero; both pipeline
//   registers empty.
module triple_timer_match_reload #(
    parameter int NUM_TIMERS = ttmr_pkg::MAX_TIMERS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ttmr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ttmr_pkg::out_item_t out_data
);
    import ttmr_pkg::*;

    // Status bits that can ever be set with this many timers
    localparam logic [FLAG_W-1:0] LIVE_MASK = FLAG_W'((1 << (3 * NUM_TIMERS)) - 1);

    // Pipeline registers
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      advance;

    // Architectural state
    logic [DATA_W-1:0] count_reg  [NUM_TIMERS];
    logic [DATA_W-1:0] reload_reg [NUM_TIMERS];
    logic [DATA_W-1:0] match1_reg [NUM_TIMERS];
    logic [DATA_W-1:0] match2_reg [NUM_TIMERS];
    logic [DATA_W-1:0] count_next [NUM_TIMERS];
    logic [CTRL_W-1:0] ctrl_reg;
    logic [CTRL_W-1:0] ctrl_next;
    logic [FLAG_W-1:0] status_reg;
    logic [FLAG_W-1:0] status_next;
    logic [FLAG_W-1:0] ack_reg;
    logic [FLAG_W-1:0] ack_next;

    // Per-lane results
    tmr_ctrl_t         lane_ctrl   [NUM_TIMERS];
    logic [DATA_W-1:0] lane_count  [NUM_TIMERS];
    tmr_flags_t        lane_flags  [NUM_TIMERS];
    logic [FLAG_W-1:0] tick_flags;

    // Decode of the held transaction
    logic       is_read;
    logic       is_write;
    logic       tick_go;
    logic       timer_bank;
    logic [1:0] field_sel;

    assign is_read    = in_item_reg.func == FUNC_READ;
    assign is_write   = in_item_reg.func == FUNC_WRITE;
    assign tick_go    = (in_item_reg.func == FUNC_TICK) && (in_item_reg.slow_ticks != '0)
                        && (in_item_reg.fast_ticks != '0);
    assign timer_bank = in_item_reg.reg_index[3:2] != BANK_GLOBAL;
    assign field_sel  = in_item_reg.reg_index[1:0];

    // Advance the held item whenever the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Timer lanes
    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_lane
        assign lane_ctrl[i].enable      = ctrl_reg[3*i];
        assign lane_ctrl[i].slow_sel    = ctrl_reg[3*i+1];
        assign lane_ctrl[i].zero_irq_en = ctrl_reg[3*i+2];
        assign lane_ctrl[i].count_up    = ctrl_reg[9+i];

        ttmr_lane u_lane (
            .ctrl       (lane_ctrl[i]),
            .count      (count_reg[i]),
            .reload     (reload_reg[i]),
            .match1     (match1_reg[i]),
            .match2     (match2_reg[i]),
            .slow_ticks (in_item_reg.slow_ticks),
            .fast_ticks (in_item_reg.fast_ticks),
            .count_next (lane_count[i]),
            .flags      (lane_flags[i])
        );
    end

    always_comb
    begin
        tick_flags = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            tick_flags[3*i +: 3] = lane_flags[i];
        end
    end

    // Counter next values: a tick steps the lane, a write replaces the value
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            count_next[i] = count_reg[i];
            if (tick_go)
            begin
                count_next[i] = lane_count[i];
            end
            else if (is_write && timer_bank && (in_item_reg.reg_index[3:2] == 2'(i))
                     && (field_sel == SEL_COUNT))
            begin
                count_next[i] = in_item_reg.write_data;
            end
        end
    end

    // Global registers
    always_comb
    begin
        ctrl_next   = ctrl_reg;
        status_next = status_reg;
        ack_next    = ack_reg;
        if (tick_go)
        begin
            // Drop acknowledged bits first, then merge this tick's events
            status_next = (status_reg & ~ack_reg) | tick_flags;
            ack_next    = '0;
        end
        else if (is_write && !timer_bank)
        begin
            unique case (in_item_reg.reg_index)
                REG_CONTROL: ctrl_next = in_item_reg.write_data[CTRL_W-1:0];
                REG_ACK:     ack_next  = in_item_reg.write_data[FLAG_W-1:0];
                default:     ;
            endcase
        end
    end

    // Result word
    always_comb
    begin
        out_item_next.read_data = '0;
        out_item_next.irq_flags = status_next;
        if (is_read)
        begin
            if (timer_bank)
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (in_item_reg.reg_index[3:2] == 2'(i))
                    begin
                        unique case (field_sel)
                            SEL_COUNT:  out_item_next.read_data = count_reg[i];
                            SEL_RELOAD: out_item_next.read_data = reload_reg[i];
                            SEL_MATCH1: out_item_next.read_data = match1_reg[i];
                            SEL_MATCH2: out_item_next.read_data = match2_reg[i];
                            default:    out_item_next.read_data = '0;
                        endcase
                    end
                end
            end
            else
            begin
                unique case (in_item_reg.reg_index)
                    REG_CONTROL: out_item_next.read_data = DATA_W'(ctrl_reg);
                    REG_STATUS:  out_item_next.read_data = DATA_W'(status_reg);
                    REG_ACK:     out_item_next.read_data = DATA_W'(ack_reg);
                    default:     out_item_next.read_data = '0;
                endcase
            end
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // State update, once per processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
                match1_reg[i] <= '0;
                match2_reg[i] <= '0;
            end
            ctrl_reg   <= '0;
            status_reg <= '0;
            ack_reg    <= '0;
        end
        else if (advance)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                count_reg[i] <= count_next[i];
                if (is_write && timer_bank && (in_item_reg.reg_index[3:2] == 2'(i)))
                begin
                    case (field_sel)
                        SEL_RELOAD: reload_reg[i] <= in_item_reg.write_data;
                        SEL_MATCH1: match1_reg[i] <= in_item_reg.write_data;
                        SEL_MATCH2: match2_reg[i] <= in_item_reg.write_data;
                        default:    ;
                    endcase
                end
            end
            ctrl_reg   <= ctrl_next;
            status_reg <= status_next;
            ack_reg    <= ack_next;
        end
    end

    // Flags of absent timers never appear
    a_live_flags : assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg & ~LIVE_MASK) == '0)
        else $error("status bit set for an absent timer");

    // A processed tick with nonzero counts consumes the pending acknowledge
    a_ack_consumed : assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tick_go) |=> (ack_reg == '0))
        else $error("pending acknowledge survived a tick");

    // Input side stalls only when both pipeline registers are full and blocked
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without back-pressure");

    // Every processed item lands in the result register
    a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item lost before the output");

    // The result carries the status word as it stands after the item
    a_flags_match : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_item_reg.irq_flags == status_reg))
        else $error("result flags differ from status");

endmodule
